>>> rtl/core/opl_pkg.sv
// shared types and constants for the one-pole lowpass with ramped time constant
package opl_pkg;

    localparam int unsigned SMP_W    = 24;
    localparam int unsigned TAUT_W   = 21;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DIV_W    = 40;
    localparam int unsigned DVS_W    = 32;
    localparam int unsigned SER_TERMS = 12;
    localparam int unsigned EXP_LIMIT = 24;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // word select bit of paddr: 0 sample_period, 1 ramp_ticks
    localparam logic REG_SAMPLE_PERIOD = 1'b0;
    localparam logic REG_RAMP_TICKS    = 1'b1;

    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd97391548;
    localparam logic [15:0] RAMP_TICKS_RST    = 16'd1;
    localparam logic [30:0] Q30_ONE           = 31'h4000_0000;
    localparam logic [24:0] Q24_ONE           = 25'h100_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SMP_A,
        ST_SMP_B,
        ST_SMP_C,
        ST_SMP_D,
        ST_SET,
        ST_SET_DIV,
        ST_TICK,
        ST_CO_CHK,
        ST_CO_RDIV,
        ST_CO_N,
        ST_SER_MUL,
        ST_SER_MULW,
        ST_SER_DIV,
        ST_POW,
        ST_POW_W,
        ST_FIN
    } t_state;

endpackage

>>> rtl/core/opl_if.sv
// valid/ready channel interfaces for input and result beats
interface opl_in_if import opl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [SMP_W-1:0]  sample_in;
    logic signed [TAUT_W-1:0] tau_target;

    modport source (output valid, cmd, sample_in, tau_target, input ready);
    modport sink   (input valid, cmd, sample_in, tau_target, output ready);
endinterface

interface opl_out_if import opl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

>>> rtl/core/opl_mul.sv
// registered signed 32x32 multiplier shared by the filter and the exponential
module opl_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

>>> rtl/core/opl_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module opl_div import opl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dvd,
    input  logic [DVS_W-1:0]  i_dvs,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quo
);
    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   shifted;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dvd;
            n_dvs  = i_dvs;
        end else if (r_busy) begin
            n_rem = ge ? DVS_W'(shifted - {1'b0, r_dvs}) : shifted[DVS_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

>>> rtl/core/one_pole_lowpass_tau_ramp_unit.sv
// one-pole lowpass: a sample steps through ST_SMP_A to ST_SMP_D, a tick without update ends in ST_TICK
// a tick that recomputes coefficients also multiplies by exp(-1) n times (n = integer part of ratio)
// set uses the serial divider, and a tick the series: 24 terms of multiply and divide
// one beat at a time; input ready only while idle, a result waits in the output register
// synchronous active-low reset: unity gain passthrough, zero time constant, one ramp tick
module one_pole_lowpass_tau_ramp_unit import opl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    opl_in_if.sink            i_in,
    opl_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    t_state r_state, n_state;

    logic [31:0] r_sample_period;
    logic [15:0] r_ramp_ticks;

    logic signed [SMP_W-1:0]  r_x, n_x;
    logic signed [TAUT_W-1:0] r_taut, n_taut;

    logic signed [SMP_W-1:0] r_prev, n_prev;
    logic [23:0]             r_coef_fb, n_coef_fb;
    logic [24:0]             r_coef_in, n_coef_in;
    logic [31:0]             r_cur_tau, n_cur_tau;
    logic signed [32:0]      r_tau_step, n_tau_step;
    logic [19:0]             r_end_tau, n_end_tau;
    logic [15:0]             r_ramp_left, n_ramp_left;
    logic                    r_neg, n_neg;

    logic signed [49:0] r_acc, n_acc;
    logic [DIV_W-1:0]   r_ratio, n_ratio;
    logic [30:0]        r_f, n_f;
    logic [30:0]        r_term, n_term;
    logic signed [32:0] r_sum, n_sum;
    logic [3:0]         r_k, n_k;
    logic               r_pass, n_pass;
    logic [30:0]        r_e1, n_e1;
    logic [30:0]        r_pow, n_pow;
    logic [4:0]         r_cnt, n_cnt;

    logic                    r_out_valid, n_out_valid;
    logic signed [SMP_W-1:0] r_out, n_out;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic               div_start;
    logic               div_done;
    logic               div_busy;
    logic [DIV_W-1:0]   div_dvd, div_quo;
    logic [DVS_W-1:0]   div_dvs;

    logic               in_acc;
    logic [19:0]        tau_clamp;
    logic [31:0]        target;
    logic signed [32:0] diff;
    logic [15:0]        ticks;
    logic signed [32:0] sum_next;
    logic signed [25:0] y_full;
    logic [25:0]        c_full;

    opl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    opl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.sample_out = r_out;

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_SAMPLE_PERIOD: prdata = r_sample_period;
            REG_RAMP_TICKS:    prdata = {16'd0, r_ramp_ticks};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RST;
            r_ramp_ticks    <= RAMP_TICKS_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SAMPLE_PERIOD: r_sample_period <= pwdata;
                REG_RAMP_TICKS:    r_ramp_ticks    <= pwdata[15:0];
                default:           r_ramp_ticks    <= r_ramp_ticks;
            endcase
        end
    end

    // shared helpers
    always_comb begin
        tau_clamp = r_taut[TAUT_W-1] ? 20'd0 : r_taut[19:0];
        target   = {tau_clamp, 12'd0};
        diff     = $signed({1'b0, target}) - $signed({1'b0, r_cur_tau});
        ticks    = (r_ramp_ticks == 16'd0) ? 16'd1 : r_ramp_ticks;
        sum_next = r_k[0] ? r_sum - $signed({2'b00, div_quo[30:0]})
                          : r_sum + $signed({2'b00, div_quo[30:0]});
        y_full   = r_acc[49:24];
        c_full   = 26'((32'({1'b0, r_pow}) + 32'd32) >> 6);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.cmd)
                        CMD_SAMPLE: n_state = ST_SMP_A;
                        CMD_TICK:   n_state = ST_TICK;
                        CMD_SET:    n_state = ST_SET;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SMP_A: n_state = ST_SMP_B;
            ST_SMP_B: n_state = ST_SMP_C;
            ST_SMP_C: n_state = ST_SMP_D;
            ST_SMP_D: begin
                if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            end
            ST_SET: n_state = (target == r_cur_tau) ? ST_IDLE : ST_SET_DIV;
            ST_SET_DIV: if (div_done) n_state = ST_IDLE;
            ST_TICK: n_state = (r_ramp_left == 16'd0) ? ST_IDLE : ST_CO_CHK;
            ST_CO_CHK: n_state = (r_cur_tau == 32'd0) ? ST_IDLE : ST_CO_RDIV;
            ST_CO_RDIV: if (div_done) n_state = ST_CO_N;
            ST_CO_N: n_state = (r_ratio[DIV_W-1:24] >= 16'(EXP_LIMIT)) ? ST_IDLE : ST_SER_MUL;
            ST_SER_MUL: n_state = ST_SER_MULW;
            ST_SER_MULW: n_state = ST_SER_DIV;
            ST_SER_DIV: begin
                if (div_done) begin
                    if (r_k == 4'(SER_TERMS) && r_pass) n_state = ST_POW;
                    else n_state = ST_SER_MUL;
                end
            end
            ST_POW: n_state = (r_cnt == 5'd0) ? ST_FIN : ST_POW_W;
            ST_POW_W: n_state = ST_POW;
            ST_FIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        n_x = r_x;  n_taut = r_taut;
        n_prev = r_prev;  n_coef_fb = r_coef_fb;  n_coef_in = r_coef_in;
        n_cur_tau = r_cur_tau;  n_tau_step = r_tau_step;  n_end_tau = r_end_tau;
        n_ramp_left = r_ramp_left;  n_neg = r_neg;
        n_acc = r_acc;  n_ratio = r_ratio;  n_f = r_f;  n_term = r_term;
        n_sum = r_sum;  n_k = r_k;  n_pass = r_pass;  n_e1 = r_e1;
        n_pow = r_pow;  n_cnt = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out = r_out;
        mul_a = '0;  mul_b = '0;
        div_start = 1'b0;
        div_dvd = '0;  div_dvs = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_x    = i_in.sample_in;
                    n_taut = i_in.tau_target;
                end
            end
            ST_SMP_A: begin
                mul_a = 32'(r_x);
                mul_b = $signed({7'd0, r_coef_in});
            end
            ST_SMP_B: begin
                mul_a = 32'(r_prev);
                mul_b = $signed({8'd0, r_coef_fb});
                n_acc = mul_p[49:0];
            end
            ST_SMP_C: n_acc = r_acc + mul_p[49:0] + 50'sd8388608;
            ST_SMP_D: begin
                if (!r_out_valid || o_out.ready) begin
                    if (y_full > 26'sd8388607)       n_out = 24'sh7FFFFF;
                    else if (y_full < -26'sd8388608) n_out = 24'sh800000;
                    else                             n_out = y_full[23:0];
                    n_prev      = n_out;
                    n_out_valid = 1'b1;
                end
            end
            ST_SET: begin
                if (target != r_cur_tau) begin
                    n_end_tau   = tau_clamp;
                    n_ramp_left = ticks;
                    n_neg       = diff[32];
                    div_start   = 1'b1;
                    div_dvd = DIV_W'(diff[32] ? -diff : diff);
                    div_dvs = DVS_W'(ticks);
                end
            end
            ST_SET_DIV: begin
                if (div_done)
                    n_tau_step = r_neg ? -$signed(div_quo[32:0]) : $signed(div_quo[32:0]);
            end
            ST_TICK: begin
                if (r_ramp_left == 16'd1) begin
                    n_cur_tau   = {r_end_tau, 12'd0};
                    n_ramp_left = 16'd0;
                end else if (r_ramp_left != 16'd0) begin
                    n_ramp_left = r_ramp_left - 16'd1;
                    n_cur_tau   = r_cur_tau + r_tau_step[31:0];
                end
            end
            ST_CO_CHK: begin
                if (r_cur_tau == 32'd0) begin
                    n_coef_fb = '0;
                    n_coef_in = Q24_ONE;
                end else begin
                    div_start = 1'b1;
                    div_dvd = {r_sample_period, 8'd0};
                    div_dvs = r_cur_tau;
                end
            end
            ST_CO_RDIV: if (div_done) n_ratio = div_quo;
            ST_CO_N: begin
                if (r_ratio[DIV_W-1:24] >= 16'(EXP_LIMIT)) begin
                    n_coef_fb = '0;
                    n_coef_in = Q24_ONE;
                end
                // first pass builds exp(-1), second pass exp(-f)
                n_f    = Q30_ONE;
                n_term = Q30_ONE;
                n_sum  = $signed({2'b00, Q30_ONE});
                n_k    = 4'd1;
                n_pass = 1'b0;
                n_cnt  = r_ratio[28:24];
            end
            ST_SER_MUL: begin
                mul_a = $signed({1'b0, r_term});
                mul_b = $signed({1'b0, r_f});
            end
            ST_SER_MULW: begin
                div_start = 1'b1;
                div_dvd = DIV_W'(mul_p[60:30]);
                div_dvs = DVS_W'(r_k);
            end
            ST_SER_DIV: begin
                if (div_done) begin
                    n_term = div_quo[30:0];
                    n_sum  = sum_next;
                    n_k    = r_k + 4'd1;
                    if (r_k == 4'(SER_TERMS)) begin
                        if (!r_pass) begin
                            n_e1   = sum_next[32] ? 31'd0 : sum_next[30:0];
                            n_f    = {r_ratio[23:0], 7'd0} >> 1;
                            n_term = Q30_ONE;
                            n_sum  = $signed({2'b00, Q30_ONE});
                            n_k    = 4'd1;
                            n_pass = 1'b1;
                        end else begin
                            n_pow = sum_next[32] ? 31'd0 : sum_next[30:0];
                        end
                    end
                end
            end
            ST_POW: begin
                mul_a = $signed({1'b0, r_pow});
                mul_b = $signed({1'b0, r_e1});
            end
            ST_POW_W: begin
                n_pow = mul_p[60:30];
                n_cnt = r_cnt - 5'd1;
            end
            ST_FIN: begin
                n_coef_fb = (c_full > 26'hFF_FFFF) ? 24'hFF_FFFF : c_full[23:0];
                n_coef_in = Q24_ONE - {1'b0, n_coef_fb};
            end
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_coef_fb   <= '0;
            r_coef_in   <= Q24_ONE;
            r_cur_tau   <= '0;
            r_tau_step  <= '0;
            r_end_tau   <= '0;
            r_ramp_left <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_coef_fb   <= n_coef_fb;
            r_coef_in   <= n_coef_in;
            r_cur_tau   <= n_cur_tau;
            r_tau_step  <= n_tau_step;
            r_end_tau   <= n_end_tau;
            r_ramp_left <= n_ramp_left;
            r_out_valid <= n_out_valid;
        end
        r_x     <= n_x;
        r_taut  <= n_taut;
        r_neg   <= n_neg;
        r_acc   <= n_acc;
        r_ratio <= n_ratio;
        r_f     <= n_f;
        r_term  <= n_term;
        r_sum   <= n_sum;
        r_k     <= n_k;
        r_pass  <= n_pass;
        r_e1    <= n_e1;
        r_pow   <= n_pow;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

    // the two coefficients always give unity dc gain
    a_coef_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_coef_fb} + r_coef_in) == Q24_ONE)
        else $error("coefficients do not sum to one");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != ST_IDLE || $past(i_in.cmd) == CMD_NONE)
        else $error("accepted beat did not start work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out))
        else $error("pending result lost");
endmodule
